@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL in this folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/lts_pkg.sv @@
// Constants, register indexes and byte mapping for the label text sanitizer.
// No dependencies.
package lts_pkg;

    localparam int LENGTH_WIDTH_DEF = 10;
    localparam int MAX_LENGTH_RESET = 199;
    localparam int MAX_RESULTS      = 4;
    localparam int CFG_INDEX_WIDTH  = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VALUE_MODE = 2'd1;

    localparam logic [7:0] UNDERSCORE = 8'h5F;

    // Control, space and everything from DEL upward.
    function automatic logic is_space_class(input logic [7:0] c);
        return (c <= 8'h20) || (c >= 8'h7F);
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return c[7:6] == 2'b11;
    endfunction

    function automatic logic [7:0] map_char(input logic [7:0] c, input logic value_mode);
        logic [7:0] m;
        m = UNDERSCORE;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
            c == 8'h2D || c == 8'h2E || c == 8'h5F) begin
            m = c;
        end else if (c == 8'h2C) begin
            m = 8'h2E;                              // ',' -> '.'
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            m = value_mode ? c : c + 8'h20;         // lower-case names only
        end else if (value_mode) begin
            if (c == 8'h2B || c == 8'h2F || c == 8'h3A || c == 8'h40) begin
                m = c;
            end else if (c == 8'h3B || c == 8'h3D) begin
                m = 8'h3A;                          // ';' '=' -> ':'
            end else if (c == 8'h5C) begin
                m = 8'h2F;                          // backslash -> '/'
            end
        end
        return m;
    endfunction

endpackage

@@ src/label_text_sanitizer.sv @@
// Label text sanitizer: byte-stream cleanup of label names and values.
// Depends on lts_pkg and assert_macros.svh.
//
//  channel  direction  handshake                 beat
//  in       sink       i_in_valid / o_in_stall   i_in_byte, i_in_last_byte
//  out      source     o_out_valid / i_out_stall o_out_byte, o_out_end_mark,
//                                                o_out_char_count, o_out_rejected
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An input beat lands in an input register; combinational mapping logic turns it into
// up to four result beats held in a four-entry result buffer.
// o_out_valid rises once the beat has moved from the input register into the result
// buffer and yielded at least one result; that move waits while the buffer is busy.
// One input beat per cycle while each byte yields at most one result and the output
// does not stall; a byte that yields more holds the input until its last result leaves.
// Reset is synchronous, active low; cfg is always ready and takes effect at once.
// o_in_stall rises while the input register holds a beat and results other than
// the one leaving this cycle are still waiting, so i_out_stall reaches it directly.
module label_text_sanitizer #(
    parameter int LENGTH_WIDTH = lts_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_in_byte,
    input  logic                                 i_in_last_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_out_end_mark,
    output logic [LENGTH_WIDTH-1:0]              o_out_char_count,
    output logic                                 o_out_rejected,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lts_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [LENGTH_WIDTH-1:0]              i_cfg_data
);
    import lts_pkg::*;

`include "assert_macros.svh"

    localparam int LW = LENGTH_WIDTH;
    localparam int PW = LENGTH_WIDTH + 2;   // position compares, no wrap
    localparam int HW = $clog2(MAX_RESULTS);
    localparam int KW = $clog2(MAX_RESULTS + 1);

    // configuration
    logic [LW-1:0] r_max_length;
    logic          r_value_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // per-string state
    logic [7:0]    r_pending_lead, n_pending_lead;
    logic          r_pending_valid, n_pending_valid;
    logic          r_held_space, n_held_space;
    logic          r_after_space, n_after_space;
    logic [LW-1:0] r_bytes_used, n_bytes_used;
    logic [LW-1:0] r_chars_kept, n_chars_kept;
    logic          r_all_underscore, n_all_underscore;
    logic          r_stopped, n_stopped;

    // result buffer
    logic [7:0]    r_buf_byte  [MAX_RESULTS];
    logic          r_buf_end   [MAX_RESULTS];
    logic [LW-1:0] r_buf_count [MAX_RESULTS];
    logic          r_buf_rej   [MAX_RESULTS];
    logic [HW-1:0] r_head;
    logic [KW-1:0] r_left;

    logic [7:0]    n_buf_byte  [MAX_RESULTS];
    logic          n_buf_end   [MAX_RESULTS];
    logic [LW-1:0] n_buf_count [MAX_RESULTS];
    logic          n_buf_rej   [MAX_RESULTS];
    logic [KW-1:0] n_left;

    logic pop, buf_free, adv, in_take;

    assign o_out_valid      = (r_left != '0);
    assign pop              = o_out_valid && !i_out_stall;
    assign buf_free         = (r_left == '0) || (r_left == KW'(1) && pop);
    assign adv              = r_in_valid && buf_free;
    assign o_in_stall       = r_in_valid && !buf_free;
    assign in_take          = i_in_valid && !o_in_stall;
    assign o_cfg_ready      = 1'b1;

    assign o_out_byte       = r_buf_byte[r_head];
    assign o_out_end_mark   = r_buf_end[r_head];
    assign o_out_char_count = r_buf_count[r_head];
    assign o_out_rejected   = r_buf_rej[r_head];

    // Whole per-byte step: pending pair, then the byte itself, then the end beat.
    always_comb begin
        logic [7:0]    c;
        logic          last;
        logic          consumed;
        logic [7:0]    lead;
        logic [7:0]    m;
        logic [PW-1:0] ml;
        logic [PW-1:0] pos;
        logic [KW-1:0] k;

        c                = r_in_byte;
        last             = r_in_last;
        consumed         = 1'b0;
        lead             = r_pending_lead;
        m                = UNDERSCORE;
        ml               = PW'(r_max_length);
        k                = '0;
        n_pending_lead   = r_pending_lead;
        n_pending_valid  = r_pending_valid;
        n_held_space     = r_held_space;
        n_after_space    = r_after_space;
        n_bytes_used     = r_bytes_used;
        n_chars_kept     = r_chars_kept;
        n_all_underscore = r_all_underscore;
        n_stopped        = r_stopped;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            n_buf_byte[i]  = '0;
            n_buf_end[i]   = 1'b0;
            n_buf_count[i] = '0;
            n_buf_rej[i]   = 1'b0;
        end

        if (n_pending_valid) begin
            n_pending_valid = 1'b0;
            n_pending_lead  = '0;
            pos = PW'(n_bytes_used) + PW'(n_held_space);
            if (c != 8'h00 && c[7] && !n_stopped && pos + PW'(2) <= ml) begin
                if (n_held_space) begin
                    n_buf_byte[k[HW-1:0]] = UNDERSCORE;
                    k = k + KW'(1);
                    n_bytes_used = n_bytes_used + LW'(1);
                    n_chars_kept = n_chars_kept + LW'(1);
                    n_held_space = 1'b0;
                end
                if (r_value_mode) begin
                    n_buf_byte[k[HW-1:0]] = lead;
                    k = k + KW'(1);
                    n_buf_byte[k[HW-1:0]] = c;
                    k = k + KW'(1);
                    n_bytes_used = n_bytes_used + LW'(2);
                    n_all_underscore = 1'b0;
                end else begin
                    n_buf_byte[k[HW-1:0]] = UNDERSCORE;
                    k = k + KW'(1);
                    n_bytes_used = n_bytes_used + LW'(1);
                end
                n_chars_kept  = n_chars_kept + LW'(1);
                n_after_space = 1'b0;
                if (PW'(n_bytes_used) + PW'(n_held_space) >= ml) n_stopped = 1'b1;
                consumed = 1'b1;
            end else if (!n_stopped) begin
                // an orphan lead byte is always space class
                if (pos >= ml) begin
                    n_stopped = 1'b1;
                end else begin
                    if (!n_after_space) n_held_space = 1'b1;
                    n_after_space = 1'b1;
                    if (PW'(n_bytes_used) + PW'(n_held_space) >= ml) n_stopped = 1'b1;
                end
            end
        end

        pos = PW'(n_bytes_used) + PW'(n_held_space);
        if (c == 8'h00) begin
            last = 1'b1;
        end else if (!consumed) begin
            if (!last && !n_stopped && is_lead(c) && pos + PW'(2) <= ml) begin
                n_pending_lead  = c;
                n_pending_valid = 1'b1;
            end else if (!n_stopped) begin
                if (pos >= ml) begin
                    n_stopped = 1'b1;
                end else if (is_space_class(c)) begin
                    if (!n_after_space) n_held_space = 1'b1;
                    n_after_space = 1'b1;
                    if (PW'(n_bytes_used) + PW'(n_held_space) >= ml) n_stopped = 1'b1;
                end else begin
                    if (n_held_space) begin
                        n_buf_byte[k[HW-1:0]] = UNDERSCORE;
                        k = k + KW'(1);
                        n_bytes_used = n_bytes_used + LW'(1);
                        n_chars_kept = n_chars_kept + LW'(1);
                        n_held_space = 1'b0;
                    end
                    m = map_char(c, r_value_mode);
                    n_buf_byte[k[HW-1:0]] = m;
                    k = k + KW'(1);
                    if (m != UNDERSCORE) n_all_underscore = 1'b0;
                    n_bytes_used  = n_bytes_used + LW'(1);
                    n_chars_kept  = n_chars_kept + LW'(1);
                    n_after_space = 1'b0;
                    if (PW'(n_bytes_used) + PW'(n_held_space) >= ml) n_stopped = 1'b1;
                end
            end
        end

        if (last) begin
            n_buf_byte[k[HW-1:0]]  = '0;
            n_buf_end[k[HW-1:0]]   = 1'b1;
            n_buf_count[k[HW-1:0]] = n_all_underscore ? '0 : n_chars_kept;
            n_buf_rej[k[HW-1:0]]   = n_all_underscore;
            k = k + KW'(1);
            n_pending_lead   = '0;
            n_pending_valid  = 1'b0;
            n_held_space     = 1'b0;
            n_after_space    = 1'b1;
            n_bytes_used     = '0;
            n_chars_kept     = '0;
            n_all_underscore = 1'b1;
            n_stopped        = 1'b0;
        end
        n_left = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length     <= LW'(MAX_LENGTH_RESET);
            r_value_mode     <= 1'b0;
            r_in_valid       <= 1'b0;
            r_pending_lead   <= '0;
            r_pending_valid  <= 1'b0;
            r_held_space     <= 1'b0;
            r_after_space    <= 1'b1;
            r_bytes_used     <= '0;
            r_chars_kept     <= '0;
            r_all_underscore <= 1'b1;
            r_stopped        <= 1'b0;
            r_head           <= '0;
            r_left           <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MAX_LENGTH: r_max_length <= i_cfg_data;
                    REG_VALUE_MODE: r_value_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_pending_lead   <= n_pending_lead;
                r_pending_valid  <= n_pending_valid;
                r_held_space     <= n_held_space;
                r_after_space    <= n_after_space;
                r_bytes_used     <= n_bytes_used;
                r_chars_kept     <= n_chars_kept;
                r_all_underscore <= n_all_underscore;
                r_stopped        <= n_stopped;
                r_head           <= '0;
                r_left           <= n_left;
            end else if (pop) begin
                r_head <= r_head + HW'(1);
                r_left <= r_left - KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last_byte;
        end
        if (adv) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                r_buf_byte[i]  <= n_buf_byte[i];
                r_buf_end[i]   <= n_buf_end[i];
                r_buf_count[i] <= n_buf_count[i];
                r_buf_rej[i]   <= n_buf_rej[i];
            end
        end
    end

    `ASSERT_ALWAYS(a_left_bound, i_clk, i_rst_n, r_left <= KW'(MAX_RESULTS), "result count overflow")
    `ASSERT_ALWAYS(a_head_bound, i_clk, i_rst_n, (KW+1)'(r_head) + (KW+1)'(r_left) <= (KW+1)'(MAX_RESULTS), "read pointer past buffer")
    `ASSERT_IMPLIES(a_pend_lead, i_clk, i_rst_n, r_pending_valid, is_lead(r_pending_lead), "pending byte is not a lead")
    `ASSERT_IMPLIES(a_held_after, i_clk, i_rst_n, r_held_space, r_after_space, "held space without space state")
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_in_valid && !buf_free, r_in_valid, "input beat dropped while blocked")

endmodule
